FILE: hw/rtl/six_axis_pd_with_yaw_bands_macros.svh
`ifndef SIX_AXIS_PD_WITH_YAW_BANDS_MACROS_SVH
`define SIX_AXIS_PD_WITH_YAW_BANDS_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SAPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sapd assertion failed");

// Delayed implication, used to check the delay from start to done.
`define SAPD_ASSERT_LAT3(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
    else $error("sapd latency assertion failed");

`endif

FILE: hw/rtl/sapd_pkg.sv
package sapd_pkg;

  localparam int ACC_W = 43;
  localparam int OUT_W = 24;

  localparam logic signed [15:0] YAW_BAND_HI = 16'sd11520;
  localparam logic signed [15:0] YAW_BAND_MID = 16'sd5760;
  localparam logic signed [15:0] YAW_BAND_LO = 16'sd640;

  localparam logic signed [OUT_W-1:0] TQ_HI = 24'sd51;
  localparam logic signed [OUT_W-1:0] TQ_MID = 24'sd26;
  localparam logic signed [OUT_W-1:0] TQ_LO = 24'sd18;

  localparam logic [12:0] SURGE_COUPLE = 13'd6488;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    REG_POS_GAINS  = 3'd0,
    REG_VEL_GAINS  = 3'd1,
    REG_ATT_GAINS  = 3'd2,
    REG_RATE_GAINS = 3'd3,
    REG_WEIGHT     = 3'd4,
    REG_BUOYANCY   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0]             pos;
    logic [47:0]             vel;
    logic [47:0]             att;
    logic [47:0]             rate;
    logic signed [OUT_W-1:0] weight;
    logic signed [OUT_W-1:0] buoy;
  } cfg_t;

  typedef struct packed {
    logic                    active;
    logic signed [OUT_W-1:0] value;
  } ovr_t;

endpackage

FILE: hw/rtl/sapd_cfg.sv
module sapd_cfg
  import sapd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [47:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        REG_POS_GAINS:  cfg.pos <= wr_data;
        REG_VEL_GAINS:  cfg.vel <= wr_data;
        REG_ATT_GAINS:  cfg.att <= wr_data;
        REG_RATE_GAINS: cfg.rate <= wr_data;
        REG_WEIGHT:     cfg.weight <= wr_data[OUT_W-1:0];
        REG_BUOYANCY:   cfg.buoy <= wr_data[OUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/sapd_axis.sv
module sapd_axis
  import sapd_pkg::*;
(
  input  logic                    clk,
  input  logic signed [15:0]      gain_p,
  input  logic signed [15:0]      err_p,
  input  logic signed [15:0]      gain_d,
  input  logic signed [15:0]      err_d,
  input  logic signed [ACC_W-1:0] addend,
  input  ovr_t                    ovr,
  output logic signed [OUT_W-1:0] result,
  output logic                    sat
);

  localparam logic signed [ACC_W-1:0] RND_HALF = 43'sd16384;
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(OUT_MIN);

  logic signed [31:0]      prod_p;
  logic signed [31:0]      prod_d;
  logic signed [ACC_W-1:0] addend_q;
  ovr_t                    ovr_q;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] quo;
  logic signed [OUT_W-1:0] result_next;
  logic                    sat_next;

  always_ff @(posedge clk) begin
    prod_p   <= gain_p * err_p;
    prod_d   <= gain_d * err_d;
    addend_q <= addend;
    ovr_q    <= ovr;
  end

  always_comb begin
    acc = (ACC_W'(prod_p) <<< 8) + (ACC_W'(prod_d) <<< 8) + addend_q;
    quo = (acc + RND_HALF) >>> 15;
    if (ovr_q.active) begin
      result_next = ovr_q.value;
      sat_next    = 1'b0;
    end else if (quo > Q_MAX) begin
      result_next = OUT_MAX;
      sat_next    = 1'b1;
    end else if (quo < Q_MIN) begin
      result_next = OUT_MIN;
      sat_next    = 1'b1;
    end else begin
      result_next = quo[OUT_W-1:0];
      sat_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    sat    <= sat_next;
  end

endmodule

FILE: hw/rtl/six_axis_pd_with_yaw_bands.sv
// Six-axis PD controller with yaw bands. A sample is taken on any clock edge with start high
// and busy low, and one may be given every cycle. Its commands appear on the result ports
// marked by a one-cycle done pulse; they must be captured in that cycle, since the
// receiver cannot stall the block. A sample passes the input register, the register after
// the gain multipliers, and the result register after rounding and saturation, in that
// order. Busy is high while reset is held and in the first cycle after it. Configuration
// writes are taken whenever cfg_ready is high and should be made while no transaction is in
// flight.
module six_axis_pd_with_yaw_bands
  import sapd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  output logic                    done,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [47:0]             cfg_data,
  input  logic signed [15:0]      pos_err_x,
  input  logic signed [15:0]      pos_err_y,
  input  logic signed [15:0]      pos_err_z,
  input  logic signed [15:0]      vel_err_x,
  input  logic signed [15:0]      vel_err_y,
  input  logic signed [15:0]      vel_err_z,
  input  logic signed [15:0]      att_err_roll,
  input  logic signed [15:0]      att_err_pitch,
  input  logic signed [15:0]      att_err_yaw,
  input  logic signed [15:0]      rate_err_roll,
  input  logic signed [15:0]      rate_err_pitch,
  input  logic signed [15:0]      rate_err_yaw,
  output logic signed [OUT_W-1:0] force_x,
  output logic signed [OUT_W-1:0] force_y,
  output logic signed [OUT_W-1:0] force_z,
  output logic signed [OUT_W-1:0] torque_roll,
  output logic signed [OUT_W-1:0] torque_pitch,
  output logic signed [OUT_W-1:0] torque_yaw,
  output logic                    saturated
);

  cfg_t cfg;

  logic accept;
  logic v0;
  logic v1;
  logic v2;

  logic signed [15:0] px;
  logic signed [15:0] py;
  logic signed [15:0] pz;
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [15:0] vz;
  logic signed [15:0] ar;
  logic signed [15:0] ap;
  logic signed [15:0] ayw;
  logic signed [15:0] rr;
  logic signed [15:0] rp;
  logic signed [15:0] ryw;

  logic signed [16:0]      py_ext;
  logic [16:0]             py_abs;
  logic [29:0]             couple_prod;
  logic signed [ACC_W-1:0] surge_add;
  logic signed [ACC_W-1:0] heave_add;
  logic                    band;
  logic signed [OUT_W-1:0] band_tq;
  ovr_t                    ovr_none;
  ovr_t                    ovr_zero;
  ovr_t                    ovr_yaw;
  logic [5:0]              sat_ax;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign done      = v2;
  assign saturated = |sat_ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      busy <= 1'b0;
      v0   <= accept;
      v1   <= v0;
      v2   <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px  <= pos_err_x;
      py  <= pos_err_y;
      pz  <= pos_err_z;
      vx  <= vel_err_x;
      vy  <= vel_err_y;
      vz  <= vel_err_z;
      ar  <= att_err_roll;
      ap  <= att_err_pitch;
      ayw <= att_err_yaw;
      rr  <= rate_err_roll;
      rp  <= rate_err_pitch;
      ryw <= rate_err_yaw;
    end
  end

  sapd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_comb begin
    py_ext      = 17'(py);
    py_abs      = py_ext[16] ? 17'(-py_ext) : 17'(py_ext);
    couple_prod = 30'(py_abs) * 30'(SURGE_COUPLE);
    surge_add   = $signed(ACC_W'(0) - ACC_W'(couple_prod));
    heave_add   = (ACC_W'(cfg.buoy) - ACC_W'(cfg.weight)) <<< 15;

    band    = 1'b1;
    band_tq = '0;
    if (ayw > YAW_BAND_HI || ayw < -YAW_BAND_HI) begin
      band_tq = (ayw > 16'sd0) ? TQ_HI : -TQ_HI;
    end else if (ayw > YAW_BAND_MID || ayw < -YAW_BAND_MID) begin
      band_tq = (ayw > 16'sd0) ? TQ_MID : -TQ_MID;
    end else if (ayw > YAW_BAND_LO || ayw < -YAW_BAND_LO) begin
      band_tq = (ayw > 16'sd0) ? TQ_LO : -TQ_LO;
    end else begin
      band = 1'b0;
    end

    ovr_none = '{active: 1'b0, value: '0};
    ovr_zero = '{active: band, value: '0};
    ovr_yaw  = '{active: band, value: band_tq};
  end

  sapd_axis u_surge (
    .clk    (clk),
    .gain_p ($signed(cfg.pos[15:0])),
    .err_p  (px),
    .gain_d ($signed(cfg.vel[15:0])),
    .err_d  (vx),
    .addend (surge_add),
    .ovr    (ovr_zero),
    .result (force_x),
    .sat    (sat_ax[0])
  );

  sapd_axis u_sway (
    .clk    (clk),
    .gain_p ($signed(cfg.pos[31:16])),
    .err_p  (py),
    .gain_d ($signed(cfg.vel[31:16])),
    .err_d  (vy),
    .addend ('0),
    .ovr    (ovr_zero),
    .result (force_y),
    .sat    (sat_ax[1])
  );

  sapd_axis u_heave (
    .clk    (clk),
    .gain_p ($signed(cfg.pos[47:32])),
    .err_p  (pz),
    .gain_d ($signed(cfg.vel[47:32])),
    .err_d  (vz),
    .addend (heave_add),
    .ovr    (ovr_none),
    .result (force_z),
    .sat    (sat_ax[2])
  );

  sapd_axis u_roll (
    .clk    (clk),
    .gain_p ($signed(cfg.att[15:0])),
    .err_p  (ar),
    .gain_d ($signed(cfg.rate[15:0])),
    .err_d  (rr),
    .addend ('0),
    .ovr    (ovr_none),
    .result (torque_roll),
    .sat    (sat_ax[3])
  );

  sapd_axis u_pitch (
    .clk    (clk),
    .gain_p ($signed(cfg.att[31:16])),
    .err_p  (ap),
    .gain_d ($signed(cfg.rate[31:16])),
    .err_d  (rp),
    .addend ('0),
    .ovr    (ovr_none),
    .result (torque_pitch),
    .sat    (sat_ax[4])
  );

  sapd_axis u_yaw (
    .clk    (clk),
    .gain_p ($signed(cfg.att[47:32])),
    .err_p  (ayw),
    .gain_d ($signed(cfg.rate[47:32])),
    .err_d  (ryw),
    .addend ('0),
    .ovr    (ovr_yaw),
    .result (torque_yaw),
    .sat    (sat_ax[5])
  );

endmodule

FILE: hw/rtl/sapd_checker.sv
`include "six_axis_pd_with_yaw_bands_macros.svh"

module sapd_checker
  import sapd_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic signed [15:0]      att_err_yaw,
  input logic signed [OUT_W-1:0] force_x,
  input logic signed [OUT_W-1:0] force_y,
  input logic signed [OUT_W-1:0] torque_yaw
);

  // Every accepted transaction yields exactly one result, marked by done.
  `SAPD_ASSERT_LAT3(a_accept_gives_done, clk, rst, start && !busy, done)
  `SAPD_ASSERT_NOW(a_done_has_accept, clk, rst, done, $past(start && !busy, 3))

  // A positive yaw error beyond the top band gives the fixed torque TQ_HI and zeroes surge and sway.
  `SAPD_ASSERT_NOW(a_top_band, clk, rst,
    done && $past(start && !busy && att_err_yaw > 16'sd11520, 3),
    torque_yaw == TQ_HI && force_x == '0 && force_y == '0)

endmodule

bind six_axis_pd_with_yaw_bands sapd_checker u_sapd_checker (.*);
